// ===== src/c3f_pkg.sv =====
// Shared types and constants of the 3x3 image filter.
package c3f_pkg;

   localparam int CHAN_BITS      = 8;
   localparam int NUM_CHAN       = 3;
   localparam int PIX_BITS       = CHAN_BITS * NUM_CHAN;
   localparam int LINE_BITS      = 2 * PIX_BITS;
   localparam int KSIZE          = 3;
   localparam int KTAPS          = KSIZE * KSIZE;
   localparam int COEF_BITS      = 16;
   localparam int COEF_ROW_BITS  = COEF_BITS * KSIZE;
   localparam int FRAME_W_BITS   = 12;
   localparam int FRAME_H_BITS   = 13;
   localparam int FRAME_W_RESET  = 2048;
   localparam int FRAME_H_RESET  = 4096;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = COEF_ROW_BITS;
   localparam int PROD_BITS      = CHAN_BITS + 1 + COEF_BITS;
   localparam int SUM_BITS       = PROD_BITS + $clog2(KTAPS);

   typedef logic [CHAN_BITS-1:0] chan_type;
   typedef logic [PIX_BITS-1:0]  pix_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COLOR_MODE   = 3'd0,
      CSR_FRAME_WIDTH  = 3'd1,
      CSR_FRAME_HEIGHT = 3'd2,
      CSR_COEF_TOP     = 3'd3,
      CSR_COEF_MID     = 3'd4,
      CSR_COEF_BOT     = 3'd5
   } csr_index_type;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_FLUSH = 1'b1
   } cmd_type;

endpackage

// ===== src/c3f_channels.sv =====
// Request and response channel interfaces of the 3x3 image filter.
interface c3f_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   c3f_pkg::chan_type  pix_c0;
   c3f_pkg::chan_type  pix_c1;
   c3f_pkg::chan_type  pix_c2;

   modport source (output valid, cmd, pix_c0, pix_c1, pix_c2, input ready);
   modport sink   (input valid, cmd, pix_c0, pix_c1, pix_c2, output ready);
endinterface

interface c3f_rsp_if;
   logic               valid;
   logic               ready;
   c3f_pkg::chan_type  out_c0;
   c3f_pkg::chan_type  out_c1;
   c3f_pkg::chan_type  out_c2;
   logic               out_last;

   modport source (output valid, out_c0, out_c1, out_c2, out_last, input ready);
   modport sink   (input valid, out_c0, out_c1, out_c2, out_last, output ready);
endinterface

// ===== src/c3f_ram.sv =====
// Generic simple dual-port RAM with registered read.
module c3f_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read at the address being written returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/conv3x3_image_filter_unit.sv =====
// Top level of the streaming 3x3 image convolution filter.

// Pixels of one frame enter in raster order on req_chan, one transaction per
// pixel (cmd = pixel) or per flush request (cmd = flush). Every interior pixel
// leaves as the 3x3 weighted sum of its neighbors, weights signed 16-bit with
// COEF_FRAC_BITS fraction bits, truncated toward zero and clamped to 0..255;
// border pixels leave unchanged. Results lag the input by one line plus one
// pixel, so after the last pixel of a frame send frame_width + 1 flush
// transactions to drain the rest (out_last marks the final pixel); a flush
// before the frame is complete, or once it is drained, yields nothing, and a
// pixel after a complete frame drops what is still pending and starts a new
// frame. The block takes one transaction every clock; req_chan.ready drops
// only when the result side backs up into the pipeline. The line store is a
// single RAM of MAX_WIDTH words holding both stored lines, read at the accept
// edge and written back as the item leaves stage 1, with a bypass for the same
// address, so it keeps pace with the input. A result passes line store read,
// multiply, and sum and clamp on its way to rsp_chan. Writing color_mode,
// frame_width or frame_height restarts the frame; weight writes take effect at
// once. Write registers only while idle.
module conv3x3_image_filter_unit #(
   parameter int MAX_WIDTH      = 2048,
   parameter int MAX_HEIGHT     = 4096,
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   c3f_req_if.sink                             req_chan,
   c3f_rsp_if.source                           rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [c3f_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [c3f_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   import c3f_pkg::*;

   localparam int COLW   = $clog2(MAX_WIDTH);
   localparam int ROWW   = $clog2(MAX_HEIGHT);
   localparam int Q_BITS = SUM_BITS - COEF_FRAC_BITS;
   localparam logic [COEF_BITS-1:0] DEF_WEIGHT =
      COEF_BITS'(((1 << COEF_FRAC_BITS) + 4) / 9);
   localparam logic [COEF_ROW_BITS-1:0] DEF_ROW = {KSIZE{DEF_WEIGHT}};
   localparam logic [COLW-1:0] WLAST_RST =
      COLW'(((MAX_WIDTH < FRAME_W_RESET) ? MAX_WIDTH : FRAME_W_RESET) - 1);
   localparam logic [ROWW-1:0] HLAST_RST =
      ROWW'(((MAX_HEIGHT < FRAME_H_RESET) ? MAX_HEIGHT : FRAME_H_RESET) - 1);

   // configuration: geometry is kept as effective last column / last row
   logic                     color_mode_ff, color_mode_in;
   logic [COLW-1:0]          wlast_ff, wlast_in;
   logic [ROWW-1:0]          hlast_ff, hlast_in;
   logic [COEF_ROW_BITS-1:0] coef_ff [KSIZE];
   logic [COEF_ROW_BITS-1:0] coef_in [KSIZE];
   logic [FRAME_W_BITS-1:0]  csr_fw;
   logic [FRAME_H_BITS-1:0]  csr_fh;
   logic                     csr_restart;

   // frame position
   logic [ROWW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [COLW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic            frame_done_ff, frame_done_in;
   logic            drain_done_ff, drain_done_in;
   logic [ROWW-1:0] cur_in_row, cur_out_row;
   logic [COLW-1:0] cur_in_col, cur_out_col;
   logic            is_pix, restart, flush_ok, pix_emit, emit_now;

   // pipeline flow
   logic accept, out_free, s3_adv, s3_free, s2_adv, s2_free, s1_adv, s1_free, s1_wr;

   // stage 1: line store read returned
   logic            s1_valid_ff, s1_valid_in;
   logic            s1_pix_ff, s1_emit_ff, s1_border_ff, s1_last_ff, s1_newer_ff;
   pix_type         s1_data_ff;
   logic [COLW-1:0] s1_addr_ff;

   // line store
   logic [COLW-1:0]      rd_addr;
   logic [LINE_BITS-1:0] ram_rd_data, line_q, wr_data;
   logic                 fwd_ff, fwd_in;
   logic [LINE_BITS-1:0] fwd_data_ff;
   pix_type              older_q, newer_q;

   // window
   pix_type win_ff [KSIZE][KSIZE];
   pix_type win_in [KSIZE][KSIZE];

   // stage 2: window settled, item waits for its products
   logic    s2_valid_ff, s2_valid_in;
   pix_type s2_value_ff, s2_value_in;
   logic    s2_conv_ff, s2_last_ff;

   // stage 3: products registered
   logic                        s3_valid_ff, s3_valid_in;
   logic signed [PROD_BITS-1:0] s3_prod_ff [NUM_CHAN][KTAPS];
   logic signed [PROD_BITS-1:0] s3_prod_in [NUM_CHAN][KTAPS];
   pix_type                     s3_value_ff;
   logic                        s3_conv_ff, s3_last_ff;

   // output register
   logic signed [SUM_BITS-1:0] sum_w [NUM_CHAN];
   logic [Q_BITS-1:0]          q_w   [NUM_CHAN];
   chan_type                   conv_w [NUM_CHAN];
   pix_type                    res_w;
   logic                       rsp_valid_ff, rsp_valid_in;
   chan_type                   rsp_c0_ff, rsp_c1_ff, rsp_c2_ff;
   logic                       rsp_last_ff;

   // ---------------------------------------------------------------------
   // Flow control: each stage moves when the one after it is empty or moving.
   // ---------------------------------------------------------------------
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s3_adv   = s3_valid_ff && out_free;
   assign s3_free  = !s3_valid_ff || out_free;
   assign s2_adv   = s2_valid_ff && s3_free;
   assign s2_free  = !s2_valid_ff || s3_free;
   // stage 1 waits on stage 2 even without a result: the window it shifts
   // still feeds the products of the item sitting in stage 2
   assign s1_adv   = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s1_adv;
   assign s1_wr    = s1_adv && s1_pix_ff;

   assign req_chan.ready = s1_free;
   assign accept         = req_chan.valid && s1_free;

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   assign csr_fw = csr_wdata[FRAME_W_BITS-1:0];
   assign csr_fh = csr_wdata[FRAME_H_BITS-1:0];
   assign csr_restart = csr_wr_en && (csr_index == CSR_COLOR_MODE ||
                                      csr_index == CSR_FRAME_WIDTH ||
                                      csr_index == CSR_FRAME_HEIGHT);

   always_comb begin
      color_mode_in = color_mode_ff;
      wlast_in      = wlast_ff;
      hlast_in      = hlast_ff;
      for (int r = 0; r < KSIZE; r++) begin
         coef_in[r] = coef_ff[r];
      end
      if (csr_wr_en) begin
         case (csr_index)
            CSR_COLOR_MODE: begin
               color_mode_in = csr_wdata[0];
            end
            CSR_FRAME_WIDTH: begin
               // zero acts as one pixel, oversize clamps to the line store
               if (csr_fw == '0) begin
                  wlast_in = '0;
               end else if (32'(csr_fw) > MAX_WIDTH) begin
                  wlast_in = COLW'(MAX_WIDTH - 1);
               end else begin
                  wlast_in = COLW'(csr_fw - FRAME_W_BITS'(1));
               end
            end
            CSR_FRAME_HEIGHT: begin
               if (csr_fh == '0) begin
                  hlast_in = '0;
               end else if (32'(csr_fh) > MAX_HEIGHT) begin
                  hlast_in = ROWW'(MAX_HEIGHT - 1);
               end else begin
                  hlast_in = ROWW'(csr_fh - FRAME_H_BITS'(1));
               end
            end
            CSR_COEF_TOP: begin
               coef_in[0] = csr_wdata[COEF_ROW_BITS-1:0];
            end
            CSR_COEF_MID: begin
               coef_in[1] = csr_wdata[COEF_ROW_BITS-1:0];
            end
            CSR_COEF_BOT: begin
               coef_in[2] = csr_wdata[COEF_ROW_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Frame position tracking, decided at the accept edge.
   // ---------------------------------------------------------------------
   assign is_pix   = (req_chan.cmd == CMD_PIXEL);
   assign restart  = is_pix && frame_done_ff;
   assign flush_ok = frame_done_ff && !drain_done_ff;

   // a pixel after a complete frame sees every position back at zero
   assign cur_in_row  = restart ? '0 : in_row_ff;
   assign cur_in_col  = restart ? '0 : in_col_ff;
   assign cur_out_row = restart ? '0 : out_row_ff;
   assign cur_out_col = restart ? '0 : out_col_ff;

   // the first result comes with the pixel one line plus one below the origin
   assign pix_emit = (cur_in_row > ROWW'(1)) ||
                     (cur_in_row == ROWW'(1) && cur_in_col != '0);
   assign emit_now = accept && (is_pix ? pix_emit : flush_ok);

   always_comb begin
      in_row_in     = in_row_ff;
      in_col_in     = in_col_ff;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      frame_done_in = frame_done_ff;
      drain_done_in = drain_done_ff;

      if (accept && is_pix) begin
         out_row_in    = cur_out_row;
         out_col_in    = cur_out_col;
         in_row_in     = cur_in_row;
         frame_done_in = 1'b0;
         drain_done_in = 1'b0;
         if (cur_in_col == wlast_ff) begin
            in_col_in = '0;
            if (cur_in_row == hlast_ff) begin
               in_row_in     = '0;
               frame_done_in = 1'b1;
            end else begin
               in_row_in = cur_in_row + ROWW'(1);
            end
         end else begin
            in_col_in = cur_in_col + COLW'(1);
         end
      end

      if (emit_now) begin
         if (cur_out_col == wlast_ff) begin
            out_col_in = '0;
            if (cur_out_row == hlast_ff) begin
               out_row_in    = '0;
               drain_done_in = 1'b1;
            end else begin
               out_row_in = cur_out_row + ROWW'(1);
            end
         end else begin
            out_col_in = cur_out_col + COLW'(1);
         end
      end

      if (csr_restart) begin
         in_row_in     = '0;
         in_col_in     = '0;
         out_row_in    = '0;
         out_col_in    = '0;
         frame_done_in = 1'b0;
         drain_done_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Line store: one word per column, {older line, newer line}.
   // ---------------------------------------------------------------------
   assign rd_addr = is_pix ? cur_in_col : out_col_ff;

   // bypass the write-back that lands at the same edge as the next read
   assign fwd_in  = accept && s1_wr && (s1_addr_ff == rd_addr);
   assign line_q  = fwd_ff ? fwd_data_ff : ram_rd_data;
   assign older_q = line_q[LINE_BITS-1:PIX_BITS];
   assign newer_q = line_q[PIX_BITS-1:0];
   // advance the column: newer line moves up, the new pixel takes its place
   assign wr_data = {newer_q, s1_data_ff};

   c3f_ram #(
      .WIDTH (LINE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_wr),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------
   // Stage 1: shift the window, pick the raw value, hand results on.
   // ---------------------------------------------------------------------
   always_comb begin
      if (accept) begin
         s1_valid_in = is_pix || flush_ok;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      for (int r = 0; r < KSIZE; r++) begin
         for (int c = 0; c < KSIZE; c++) begin
            win_in[r][c] = win_ff[r][c];
         end
      end
      if (s1_wr) begin
         for (int r = 0; r < KSIZE; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = older_q;
         win_in[1][2] = newer_q;
         win_in[2][2] = s1_data_ff;
      end
   end

   // the center after the shift is the right middle tap before it; a flush
   // takes the stored pixel straight from the line store
   always_comb begin
      if (s1_pix_ff) begin
         s2_value_in = win_ff[1][2];
      end else if (s1_newer_ff) begin
         s2_value_in = newer_q;
      end else begin
         s2_value_in = older_q;
      end
   end

   always_comb begin
      if (s1_adv && s1_emit_ff) begin
         s2_valid_in = 1'b1;
      end else if (s2_adv) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: multiply the settled window by the weights.
   // ---------------------------------------------------------------------
   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         for (int r = 0; r < KSIZE; r++) begin
            for (int c = 0; c < KSIZE; c++) begin
               s3_prod_in[ch][r*KSIZE + c] = PROD_BITS'(
                  $signed({1'b0, win_ff[r][c][CHAN_BITS*ch +: CHAN_BITS]}) *
                  $signed(coef_ff[r][COEF_BITS*c +: COEF_BITS]));
            end
         end
      end
   end

   always_comb begin
      if (s2_adv) begin
         s3_valid_in = 1'b1;
      end else if (s3_adv) begin
         s3_valid_in = 1'b0;
      end else begin
         s3_valid_in = s3_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: sum nine products, drop the fraction, clamp to a byte.
   // ---------------------------------------------------------------------
   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         sum_w[ch] = '0;
         for (int t = 0; t < KTAPS; t++) begin
            sum_w[ch] = sum_w[ch] + SUM_BITS'(s3_prod_ff[ch][t]);
         end
         q_w[ch] = sum_w[ch][SUM_BITS-1:COEF_FRAC_BITS];
         if (sum_w[ch][SUM_BITS-1] || sum_w[ch] == '0) begin
            conv_w[ch] = '0;
         end else if (q_w[ch] > Q_BITS'({CHAN_BITS{1'b1}})) begin
            conv_w[ch] = '1;
         end else begin
            conv_w[ch] = q_w[ch][CHAN_BITS-1:0];
         end
      end
      res_w = s3_conv_ff ? {conv_w[2], conv_w[1], conv_w[0]} : s3_value_ff;
   end

   always_comb begin
      if (s3_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= 1'b1;
         wlast_ff      <= WLAST_RST;
         hlast_ff      <= HLAST_RST;
         for (int r = 0; r < KSIZE; r++) begin
            coef_ff[r] <= DEF_ROW;
         end
         in_row_ff     <= '0;
         in_col_ff     <= '0;
         out_row_ff    <= '0;
         out_col_ff    <= '0;
         frame_done_ff <= 1'b0;
         drain_done_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fwd_ff        <= 1'b0;
         for (int r = 0; r < KSIZE; r++) begin
            for (int c = 0; c < KSIZE; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         color_mode_ff <= color_mode_in;
         wlast_ff      <= wlast_in;
         hlast_ff      <= hlast_in;
         for (int r = 0; r < KSIZE; r++) begin
            coef_ff[r] <= coef_in[r];
         end
         in_row_ff     <= in_row_in;
         in_col_ff     <= in_col_in;
         out_row_ff    <= out_row_in;
         out_col_ff    <= out_col_in;
         frame_done_ff <= frame_done_in;
         drain_done_ff <= drain_done_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         s3_valid_ff   <= s3_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (accept) begin
            fwd_ff <= fwd_in;
         end
         for (int r = 0; r < KSIZE; r++) begin
            for (int c = 0; c < KSIZE; c++) begin
               win_ff[r][c] <= win_in[r][c];
            end
         end
      end
   end

   // payload: hold unless the stage loads
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff    <= is_pix;
         s1_emit_ff   <= is_pix ? pix_emit : flush_ok;
         s1_border_ff <= (cur_out_row == '0) || (cur_out_row == hlast_ff) ||
                         (cur_out_col == '0) || (cur_out_col == wlast_ff);
         s1_last_ff   <= (cur_out_row == hlast_ff) && (cur_out_col == wlast_ff);
         s1_newer_ff  <= (out_row_ff == hlast_ff);
         s1_data_ff   <= {req_chan.pix_c2, req_chan.pix_c1, req_chan.pix_c0};
         s1_addr_ff   <= rd_addr;
         fwd_data_ff  <= wr_data;
      end
      if (s1_adv && s1_emit_ff) begin
         s2_value_ff <= s2_value_in;
         s2_conv_ff  <= s1_pix_ff && !s1_border_ff;
         s2_last_ff  <= s1_last_ff;
      end
      if (s2_adv) begin
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            for (int t = 0; t < KTAPS; t++) begin
               s3_prod_ff[ch][t] <= s3_prod_in[ch][t];
            end
         end
         s3_value_ff <= s2_value_ff;
         s3_conv_ff  <= s2_conv_ff;
         s3_last_ff  <= s2_last_ff;
      end
      if (s3_adv) begin
         // drop green and blue in gray mode
         rsp_c0_ff   <= res_w[CHAN_BITS-1:0];
         rsp_c1_ff   <= color_mode_ff ? res_w[2*CHAN_BITS-1:CHAN_BITS] : '0;
         rsp_c2_ff   <= color_mode_ff ? res_w[3*CHAN_BITS-1:2*CHAN_BITS] : '0;
         rsp_last_ff <= s3_last_ff;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_c0   = rsp_c0_ff;
   assign rsp_chan.out_c1   = rsp_c1_ff;
   assign rsp_chan.out_c2   = rsp_c2_ff;
   assign rsp_chan.out_last = rsp_last_ff;

endmodule

// ===== verif/conv3x3_image_filter_unit_test.sv =====
// Self-checking testbench of the 3x3 image filter: scoreboard class and stream drivers.
`timescale 1ns / 100ps

module conv3x3_image_filter_unit_test;

   import c3f_pkg::*;

   typedef struct packed {
      chan_type c0;
      chan_type c1;
      chan_type c2;
      logic     last;
   } out_pixel_type;

   class pixel_scoreboard;
      localparam int LINE_DEPTH = 2048;
      localparam int LINES_MAX  = 4096;
      localparam int FRAC_BITS  = 12;
      localparam int MEAN_TAP   = ((1 << FRAC_BITS) + 4) / 9;
      localparam int CHAN_MAX   = 255;

      logic                      color_rgb;
      logic [FRAME_W_BITS-1:0]   width_reg;
      logic [FRAME_H_BITS-1:0]   height_reg;
      logic [COEF_ROW_BITS-1:0]  coef_row [KSIZE];
      pix_type                   older_line [LINE_DEPTH];
      pix_type                   newer_line [LINE_DEPTH];
      pix_type                   win [KSIZE][KSIZE];
      int unsigned               in_row, in_col, out_row, out_col;
      bit                        frame_done, drain_done;
      out_pixel_type             expected_pixels [$];
      int unsigned               mismatches;

      function new();
         mismatches = 0;
         reset_state();
      endfunction

      function void restart_frame();
         in_row = 0;
         in_col = 0;
         out_row = 0;
         out_col = 0;
         frame_done = 0;
         drain_done = 0;
      endfunction

      function void reset_state();
         color_rgb  = 1'b1;
         width_reg  = FRAME_W_BITS'(FRAME_W_RESET);
         height_reg = FRAME_H_BITS'(FRAME_H_RESET);
         for (int r = 0; r < KSIZE; r++)
            for (int k = 0; k < KSIZE; k++)
               coef_row[r][COEF_BITS*k +: COEF_BITS] = 16'(MEAN_TAP);
         foreach (older_line[i]) older_line[i] = '0;
         foreach (newer_line[i]) newer_line[i] = '0;
         foreach (win[r, c]) win[r][c] = '0;
         restart_frame();
         expected_pixels.delete();
      endfunction

      function int unsigned eff_width();
         if (width_reg == 0) return 1;
         if (width_reg > LINE_DEPTH) return LINE_DEPTH;
         return width_reg;
      endfunction

      function int unsigned eff_height();
         if (height_reg == 0) return 1;
         if (height_reg > LINES_MAX) return LINES_MAX;
         return height_reg;
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [CSR_DATA_BITS-1:0] value);
         case (index)
            CSR_COLOR_MODE:   begin color_rgb  = value[0];              restart_frame(); end
            CSR_FRAME_WIDTH:  begin width_reg  = value[FRAME_W_BITS-1:0]; restart_frame(); end
            CSR_FRAME_HEIGHT: begin height_reg = value[FRAME_H_BITS-1:0]; restart_frame(); end
            CSR_COEF_TOP:     coef_row[0] = value[COEF_ROW_BITS-1:0];
            CSR_COEF_MID:     coef_row[1] = value[COEF_ROW_BITS-1:0];
            CSR_COEF_BOT:     coef_row[2] = value[COEF_ROW_BITS-1:0];
            default: ;
         endcase
      endfunction

      function longint tap_weight(int r, int c);
         return longint'($signed(coef_row[r][COEF_BITS*c +: COEF_BITS]));
      endfunction

      // Weighted 3x3 sum per channel, negative sums clip to zero, big ones to full scale.
      function pix_type convolve();
         pix_type res;
         longint  acc;
         int      nch;
         res = '0;
         nch = color_rgb ? NUM_CHAN : 1;
         for (int ch = 0; ch < nch; ch++) begin
            acc = 0;
            for (int r = 0; r < KSIZE; r++)
               for (int c = 0; c < KSIZE; c++)
                  acc += longint'(win[r][c][CHAN_BITS*ch +: CHAN_BITS]) * tap_weight(r, c);
            if (acc > 0) begin
               acc = acc >>> FRAC_BITS;
               res[CHAN_BITS*ch +: CHAN_BITS] = (acc > CHAN_MAX) ? '1 : acc[CHAN_BITS-1:0];
            end
         end
         return res;
      endfunction

      function void emit(pix_type value);
         out_pixel_type p;
         int unsigned   w, h;
         w = eff_width();
         h = eff_height();
         if (!color_rgb) value[PIX_BITS-1:CHAN_BITS] = '0;
         p.c0   = value[0 +: CHAN_BITS];
         p.c1   = value[CHAN_BITS +: CHAN_BITS];
         p.c2   = value[2*CHAN_BITS +: CHAN_BITS];
         p.last = (out_row == h - 1 && out_col == w - 1);
         expected_pixels.push_back(p);
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
            if (out_row >= h) begin
               out_row = 0;
               drain_done = 1;
            end
         end
      endfunction

      // Returns 1 unless the transaction is a flush that the block ignores.
      function bit note_request(cmd_type cmd, chan_type c0, chan_type c1, chan_type c2);
         int unsigned w, h, c, r;
         pix_type     pix, corner, top, mid;
         bit          border;
         w = eff_width();
         h = eff_height();
         if (cmd == CMD_FLUSH) begin
            if (!frame_done || drain_done) return 0;
            c = (out_col < w) ? out_col : w - 1;
            emit((out_row == h - 1) ? newer_line[c] : older_line[c]);
            return 1;
         end
         if (frame_done) restart_frame();
         pix = {8'h00, 8'h00, c0};
         if (color_rgb) pix = {c2, c1, c0};
         c = (in_col < w) ? in_col : w - 1;
         r = in_row;
         corner = older_line[w - 1];
         top = older_line[c];
         mid = newer_line[c];
         older_line[c] = mid;
         newer_line[c] = pix;
         for (int k = 0; k < KSIZE; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
         end
         win[0][2] = top;
         win[1][2] = mid;
         win[2][2] = pix;
         if (r >= 2 || (r == 1 && c >= 1)) begin
            if (c == 0) begin
               emit(corner);
            end else begin
               border = (out_row == 0 || out_row == h - 1 || out_col == 0 || out_col == w - 1);
               emit(border ? win[1][1] : convolve());
            end
         end
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) begin
               in_row = 0;
               frame_done = 1;
            end
         end
         return 1;
      endfunction

      task flag_mismatch(string msg);
         mismatches++;
         $display("%0t MISMATCH: %s", $realtime, msg);
      endtask

      task check_response(chan_type c0, chan_type c1, chan_type c2, logic last);
         out_pixel_type want;
         if (expected_pixels.size() == 0) begin
            flag_mismatch($sformatf("unexpected pixel %h %h %h last %b", c0, c1, c2, last));
            return;
         end
         want = expected_pixels.pop_front();
         if (c0 !== want.c0 || c1 !== want.c1 || c2 !== want.c2 || last !== want.last)
            flag_mismatch($sformatf("got %h %h %h last %b, want %h %h %h last %b",
                                    c0, c1, c2, last, want.c0, want.c1, want.c2, want.last));
      endtask
   endclass

   localparam int RANDOM_ITEMS  = 950;
   localparam int SETTLE_CYCLES = 12;
   localparam int DRAIN_LIMIT   = 20000;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 3'd7;
   localparam logic [COEF_ROW_BITS-1:0]  ROW_POS_MAX = {3{16'h7FFF}};
   localparam logic [COEF_ROW_BITS-1:0]  ROW_NEG_MAX = {3{16'h8000}};
   localparam logic [COEF_ROW_BITS-1:0]  ROW_UNITY   = {3{16'h1000}};
   localparam logic [COEF_ROW_BITS-1:0]  ROW_MEAN    = {3{16'h01C7}};
   localparam chan_type MID_LEVEL = 8'd50;

   typedef enum {FRAME_CLEAN, FRAME_CUT_DRAIN, FRAME_NOISE} frame_style_type;
   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_wr_en;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_wdata;

   c3f_req_if req_if ();
   c3f_rsp_if rsp_if ();

   int unsigned     send_idle_pct = 0;
   int unsigned     rsp_stall_pct = 0;
   int unsigned     counted_items = 0;
   bit              pressure_done = 0;
   pixel_scoreboard sb;

   conv3x3_image_filter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stall the result side at the rate of the current phase.
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Check every result transaction against the oldest expected pixel.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_response(rsp_if.out_c0, rsp_if.out_c1, rsp_if.out_c2, rsp_if.out_last);
   end

   // Hard stop in case the block hangs.
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Bias channel values toward the extremes so that clipping shows up often.
   function automatic chan_type rand_chan();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return chan_type'($urandom_range(255));
      endcase
   endfunction

   // Mix full-range weights, extremes and small mean-like weights per tap.
   function automatic logic [COEF_ROW_BITS-1:0] rand_coef_row();
      logic [COEF_ROW_BITS-1:0] row;
      int                       v;
      for (int k = 0; k < KSIZE; k++) begin
         case ($urandom_range(9))
            0, 1, 2: v = $urandom_range(16'hFFFF);
            3:       v = 16'h7FFF;
            4:       v = 16'h8000;
            5:       v = 0;
            default: v = int'($urandom_range(1500)) - 500;
         endcase
         row[COEF_BITS*k +: COEF_BITS] = v[COEF_BITS-1:0];
      end
      return row;
   endfunction

   // Mostly tiny frames; a zero width or height now and then.
   function automatic logic [FRAME_W_BITS-1:0] rand_width();
      case ($urandom_range(9))
         0:       return FRAME_W_BITS'($urandom_range(3));
         1, 2:    return FRAME_W_BITS'($urandom_range(24, 9));
         default: return FRAME_W_BITS'($urandom_range(8, 1));
      endcase
   endfunction

   function automatic logic [FRAME_H_BITS-1:0] rand_height();
      case ($urandom_range(9))
         0:       return FRAME_H_BITS'($urandom_range(2));
         1:       return FRAME_H_BITS'($urandom_range(12, 7));
         default: return FRAME_H_BITS'($urandom_range(6, 1));
      endcase
   endfunction

   task automatic set_idle_mode(idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 79; rsp_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  rsp_stall_pct = 79; end
         default:       begin send_idle_pct = 19; rsp_stall_pct = 19; end
      endcase
   endtask

   // Drive one request transaction, hold it until accepted, then log it.
   task automatic push_item(cmd_type cmd, chan_type c0, chan_type c1, chan_type c2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.cmd    <= cmd;
      req_if.pix_c0 <= c0;
      req_if.pix_c1 <= c1;
      req_if.pix_c2 <= c2;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (sb.note_request(cmd, c0, c1, c2)) counted_items++;
   endtask

   task automatic push_pixel();
      push_item(CMD_PIXEL, rand_chan(), rand_chan(), rand_chan());
   endtask

   task automatic push_flush();
      push_item(CMD_FLUSH, rand_chan(), rand_chan(), rand_chan());
   endtask

   // Drop valid and wait until every expected pixel has come out.
   task automatic drain_outputs();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Flushes that yield nothing may still be in the pipe: give them time.
   task automatic settle();
      drain_outputs();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Drive one register write; the caller drops the enable after a batch.
   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_register(index, data);
   endtask

   task automatic program_frame(logic color, logic [FRAME_W_BITS-1:0] w,
                                logic [FRAME_H_BITS-1:0] h,
                                logic [COEF_ROW_BITS-1:0] top, mid, bot, bit touch_spare);
      settle();
      if (touch_spare) begin
         csr_write(CSR_SPARE_A, CSR_DATA_BITS'({$urandom(), $urandom()}));
         csr_write(CSR_SPARE_B, CSR_DATA_BITS'({$urandom(), $urandom()}));
      end
      csr_write(CSR_COLOR_MODE, CSR_DATA_BITS'(color));
      csr_write(CSR_FRAME_WIDTH, CSR_DATA_BITS'(w));
      csr_write(CSR_FRAME_HEIGHT, CSR_DATA_BITS'(h));
      csr_write(CSR_COEF_TOP, top);
      csr_write(CSR_COEF_MID, mid);
      csr_write(CSR_COEF_BOT, bot);
      csr_wr_en <= 1'b0;
   endtask

   // Geometry is always rewritten so that each phase starts on a fresh frame.
   task automatic program_random();
      settle();
      if ($urandom_range(19) == 0)
         csr_write(CSR_SPARE_A, CSR_DATA_BITS'({$urandom(), $urandom()}));
      if ($urandom_range(9) < 6)
         csr_write(CSR_COLOR_MODE, CSR_DATA_BITS'($urandom_range(1)));
      csr_write(CSR_FRAME_WIDTH, CSR_DATA_BITS'(rand_width()));
      csr_write(CSR_FRAME_HEIGHT, CSR_DATA_BITS'(rand_height()));
      if ($urandom_range(9) < 6) csr_write(CSR_COEF_TOP, rand_coef_row());
      if ($urandom_range(9) < 6) csr_write(CSR_COEF_MID, rand_coef_row());
      if ($urandom_range(9) < 6) csr_write(CSR_COEF_BOT, rand_coef_row());
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_frame(frame_style_type style);
      int unsigned w, h, pause_at;
      w = sb.eff_width();
      h = sb.eff_height();
      case (style)
         FRAME_CLEAN: begin
            // Pause the sender once for sure after results have started, then
            // now and then.
            if (w * h > w + 2 && (!pressure_done || $urandom_range(19) == 0))
               pause_at = $urandom_range(w * h - 1, w + 2);
            else
               pause_at = w * h;
            for (int i = 0; i < w * h; i++) begin
               if (i == pause_at) begin
                  drain_outputs();
                  pressure_done = 1;
               end
               push_pixel();
            end
            // One line plus one pixel is pending; extra flushes are ignored.
            repeat (w + 1 + $urandom_range(2)) push_flush();
         end
         FRAME_CUT_DRAIN: begin
            // Leave part of the drain pending; the next pixel drops it.
            repeat (w * h) push_pixel();
            repeat ($urandom_range(w)) push_flush();
         end
         default: begin
            repeat ($urandom_range(30, 5)) begin
               if ($urandom_range(3) == 0) push_flush();
               else push_pixel();
            end
         end
      endcase
   endtask

   function automatic frame_style_type pick_style();
      int unsigned roll;
      roll = $urandom_range(19);
      if (roll < 15) return FRAME_CLEAN;
      if (roll < 18) return FRAME_CUT_DRAIN;
      return FRAME_NOISE;
   endfunction

   initial begin
      int unsigned random_start;
      int unsigned phase;
      int          row;

      sb = new();
      reset         <= 1'b1;
      req_if.valid  <= 1'b0;
      req_if.cmd    <= CMD_PIXEL;
      req_if.pix_c0 <= '0;
      req_if.pix_c1 <= '0;
      req_if.pix_c2 <= '0;
      csr_wr_en     <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Flushes before any frame is complete: the block must ignore them.
      push_flush();
      push_flush();

      // 3x3 RGB frame: the center tap clips low on red, high on green and
      // lands in range on blue; unused register indexes take random writes.
      program_frame(1'b1, FRAME_W_BITS'(3), FRAME_H_BITS'(3),
                    ROW_NEG_MAX, ROW_POS_MAX, ROW_UNITY, 1'b1);
      for (int i = 0; i < 9; i++) begin
         row = i / 3;
         push_item(CMD_PIXEL, (row < 2) ? '1 : '0, (row > 0) ? '1 : '0,
                   (row == 2) ? MID_LEVEL : '0);
      end
      // Drain only one pixel, then start a new frame: the rest is dropped.
      push_flush();
      push_pixel();

      // Gray single-line frame: nothing leaves before the flushes; the last
      // flush finds the frame drained.
      program_frame(1'b0, FRAME_W_BITS'(2), FRAME_H_BITS'(1), ROW_NEG_MAX, '0, ROW_POS_MAX, 1'b0);
      push_pixel();
      push_pixel();
      repeat (3) push_flush();

      // Zero width and height act as one pixel.
      program_frame(1'b1, FRAME_W_BITS'(0), FRAME_H_BITS'(0), ROW_MEAN, ROW_MEAN, ROW_MEAN, 1'b0);
      push_pixel();
      repeat (2) push_flush();

      // Extreme geometry, including values clamped to the line store depth:
      // a short burst into each, the frame left unfinished, then a full 1x1 frame.
      phase = 0;
      set_idle_mode(idle_mode_type'(phase++ % 4));
      program_frame(1'b1, FRAME_W_BITS'(2048), FRAME_H_BITS'(2),
                    rand_coef_row(), rand_coef_row(), rand_coef_row(), 1'b0);
      run_frame(FRAME_NOISE);
      set_idle_mode(idle_mode_type'(phase++ % 4));
      program_frame(1'b0, FRAME_W_BITS'(0), FRAME_H_BITS'(8191),
                    rand_coef_row(), rand_coef_row(), rand_coef_row(), 1'b0);
      run_frame(FRAME_NOISE);
      set_idle_mode(idle_mode_type'(phase++ % 4));
      program_frame(1'b1, FRAME_W_BITS'(4095), FRAME_H_BITS'(1),
                    rand_coef_row(), rand_coef_row(), rand_coef_row(), 1'b0);
      run_frame(FRAME_NOISE);
      set_idle_mode(idle_mode_type'(phase++ % 4));
      program_frame(1'b0, FRAME_W_BITS'(1), FRAME_H_BITS'(1),
                    rand_coef_row(), rand_coef_row(), rand_coef_row(), 1'b0);
      run_frame(FRAME_CLEAN);

      // Random phases: new settings, then a few frames, mostly well formed.
      random_start = counted_items;
      while (counted_items - random_start < RANDOM_ITEMS) begin
         set_idle_mode(idle_mode_type'(phase++ % 4));
         program_random();
         repeat ($urandom_range(3, 1)) run_frame(pick_style());
      end

      // Wait out the remaining results, bounded, then the pipeline latency.
      req_if.valid <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && sb.pending() != 0; n++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.flag_mismatch($sformatf("%0d expected pixels never arrived", sb.pending()));

      if (sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
